>>> rtl/gou_pkg.sv
// Shared types, constants and fixed-point helpers for the gradient optimizer update.
// Used by the optimizer, square root and divider modules and by the checker.
// No dependencies.
package gou_pkg;

    localparam int ENTRY_COUNT_DEF = 1024;
    localparam int INDEX_W         = 10;
    localparam int VAL_W           = 32;
    localparam int RATE_W          = 16;
    localparam int OPT_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int ROW_W           = 4 * VAL_W;
    localparam int WIDE_W          = 68;
    localparam int ROOT_W          = 24;
    localparam int RADICAND_W      = 2 * ROOT_W;
    localparam int DIVISOR_W       = ROOT_W + 1;
    localparam int DIVIDEND_W      = 49;

    typedef logic signed [WIDE_W-1:0] wide_t;

    // optimizer codes
    localparam logic [OPT_W-1:0] OPT_NONE     = 3'd0;
    localparam logic [OPT_W-1:0] OPT_SGD      = 3'd1;
    localparam logic [OPT_W-1:0] OPT_MOMENTUM = 3'd2;
    localparam logic [OPT_W-1:0] OPT_NESTEROV = 3'd3;
    localparam logic [OPT_W-1:0] OPT_ADAGRAD  = 3'd4;
    localparam logic [OPT_W-1:0] OPT_RMSPROP  = 3'd5;
    localparam logic [OPT_W-1:0] OPT_ADAM     = 3'd6;
    localparam logic [OPT_W-1:0] OPT_RESERVED = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIMIZER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LRATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

    localparam logic [RATE_W-1:0] LRATE_RESET    = 16'd655;
    localparam logic [RATE_W-1:0] MOMENTUM_RESET = 16'd58982;

    localparam logic [RATE_W:0]        ONE_Q16        = 17'd65536;
    localparam logic signed [17:0]     BETA2_Q16      = 18'sd65470;
    localparam logic signed [8:0]      ONE_M_BETA2    = 9'sd66;

    localparam wide_t VAL_MAX = (wide_t'(1) <<< (VAL_W - 1)) - wide_t'(1);
    localparam wide_t VAL_MIN = -(wide_t'(1) <<< (VAL_W - 1));

    // round to nearest, ties toward plus infinity, drop 16 fraction bits
    function automatic wide_t rnd16(input wide_t x);
        rnd16 = (x + wide_t'(32768)) >>> 16;
    endfunction

    function automatic logic clip_val(input wide_t x);
        clip_val = (x > VAL_MAX) || (x < VAL_MIN);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input wide_t x);
        wide_t y;
        y = x;
        if (x > VAL_MAX)
        begin
            y = VAL_MAX;
        end
        else if (x < VAL_MIN)
        begin
            y = VAL_MIN;
        end
        sat_val = y[VAL_W-1:0];
    endfunction

endpackage

>>> rtl/gou_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds one parameter row per entry; no dependencies.
module gou_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/gou_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on gou_pkg for widths.
module gou_isqrt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [gou_pkg::RADICAND_W-1:0]       radicand,
    output logic                                 done,
    output logic [gou_pkg::ROOT_W-1:0]           root
);

    localparam int CNT_W = $clog2(gou_pkg::ROOT_W + 1);
    localparam int REM_W = gou_pkg::ROOT_W + 3;

    logic                               busy_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [gou_pkg::RADICAND_W-1:0]     rad_reg;
    logic [REM_W-1:0]                   rem_reg;
    logic [REM_W-1:0]                   rem_try;
    logic [REM_W-1:0]                   trial;

    assign rem_try = {rem_reg[REM_W-3:0], rad_reg[gou_pkg::RADICAND_W-1 -: 2]};
    assign trial   = REM_W'({root, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(gou_pkg::ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand;
            rem_reg <= '0;
            root    <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[gou_pkg::RADICAND_W-3:0], 2'b00};
            if (rem_try >= trial)
            begin
                rem_reg <= rem_try - trial;
                root    <= {root[gou_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try;
                root    <= {root[gou_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

>>> rtl/gou_div.sv
// Restoring signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on gou_pkg for widths.
module gou_div (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic signed [gou_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [gou_pkg::DIVISOR_W-1:0]            divisor,
    output logic                                     done,
    output logic signed [gou_pkg::DIVIDEND_W-1:0]    quotient
);

    localparam int MAG_W = gou_pkg::DIVIDEND_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam int REM_W = gou_pkg::DIVISOR_W + 1;

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          neg_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [gou_pkg::DIVISOR_W-1:0] dvs_reg;
    logic [REM_W-1:0]              rem_try;
    logic [gou_pkg::DIVIDEND_W-1:0] abs_in;

    assign rem_try  = {rem_reg[REM_W-2:0], mag_reg[MAG_W-1]};
    assign abs_in   = dividend[gou_pkg::DIVIDEND_W-1] ? -dividend : dividend;
    assign quotient = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[gou_pkg::DIVIDEND_W-1];
            mag_reg <= abs_in[MAG_W-1:0];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (rem_try >= REM_W'(dvs_reg))
            begin
                rem_reg <= rem_try - REM_W'(dvs_reg);
                mag_reg <= {mag_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try;
                mag_reg <= {mag_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

endmodule

>>> rtl/gradient_optimizer_update.sv
// Load, SGD, momentum and Nesterov go from the accepted transaction straight to write-back;
// AdaGrad, RMSProp and Adam add a square root, then a divide, before write-back.
// Index reduction runs first when ENTRY_COUNT is below 1024.
// Flow: one item at a time; the input is ready again in the cycle in which the result is shown.
// Reset clears control and configuration (mode SGD, rate 655, momentum 58982); memory is
// undefined until a load transaction writes the entry.
module gradient_optimizer_update #(
    parameter int ENTRY_COUNT = gou_pkg::ENTRY_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,   // entry_index[9:0], value[41:10]
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // entry_out[9:0], weight_out[41:10],
                                                          // status[43:42]
    input  logic                              cfg_we,
    input  logic [gou_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gou_pkg::RATE_W-1:0]        cfg_data
);

    localparam int ADDR_W   = $clog2(ENTRY_COUNT);
    localparam bit NEED_RED = ENTRY_COUNT < (1 << gou_pkg::INDEX_W);
    localparam int VW       = gou_pkg::VAL_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RED  = 4'd1;
    localparam logic [3:0] S_READ = 4'd2;
    localparam logic [3:0] S_MUL1 = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_MUL3 = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    typedef logic signed [VW-1:0] val_t;

    logic [3:0]                        state_reg, state_next;
    logic [gou_pkg::OPT_W-1:0]         opt_cfg_reg;
    logic [gou_pkg::RATE_W-1:0]        lr_reg;
    logic [gou_pkg::RATE_W-1:0]        mu_reg;

    logic [gou_pkg::OPT_W-1:0]         opt_reg;
    logic                              load_reg;
    logic [gou_pkg::INDEX_W-1:0]       idx_reg;
    logic [gou_pkg::INDEX_W-1:0]       red_reg;
    logic [3:0]                        k_reg;
    val_t                              val_reg;

    logic                              ram_we;
    logic                              ram_re;
    logic [ADDR_W-1:0]                 addr;
    logic [gou_pkg::ROW_W-1:0]         ram_wdata;
    logic [gou_pkg::ROW_W-1:0]         ram_rdata;

    val_t                              w_old, v_old, m1_old, m2_old;

    logic signed [16:0]                mu_s, lr_s;
    logic signed [17:0]                omu_s;

    logic signed [48:0]                p_mu_v, p_lr_g, p_omu_g, p_mu_m1, p_b2_m2, p_mu_vn;
    logic signed [48:0]                p_lr_num;
    logic signed [63:0]                p_gg;
    logic signed [47:0]                sqr_reg;
    logic signed [65:0]                p_omu_sq;
    logic signed [56:0]                p_66_sq;

    val_t                              v_new_reg, m1_new_reg, m2_new_reg;
    logic                              acc_clip_reg;
    logic                              adaptive;

    gou_pkg::wide_t                    v_mom_w, v_ada_w, v_rms_w, m1_w, m2_w, sqr_w;
    val_t                              root_src;

    logic                              sqrt_start, sqrt_done;
    logic [gou_pkg::ROOT_W-1:0]        root;
    logic                              div_start, div_done;
    logic signed [gou_pkg::DIVIDEND_W-1:0] quotient;

    gou_pkg::wide_t                    w_sum;
    val_t                              w_res_reg;
    logic [gou_pkg::STATUS_W-1:0]      status_reg;
    logic                              w_clip;

    logic                              s_acc;
    logic                              out_free;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid || m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opt_cfg_reg <= gou_pkg::OPT_SGD;
            lr_reg      <= gou_pkg::LRATE_RESET;
            mu_reg      <= gou_pkg::MOMENTUM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gou_pkg::CFG_OPTIMIZER: opt_cfg_reg <= cfg_data[gou_pkg::OPT_W-1:0];
                gou_pkg::CFG_LRATE:     lr_reg      <= cfg_data;
                gou_pkg::CFG_MOMENTUM:  mu_reg      <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign mu_s  = $signed({1'b0, mu_reg});
    assign lr_s  = $signed({1'b0, lr_reg});
    assign omu_s = $signed({1'b0, gou_pkg::ONE_Q16 - {1'b0, mu_reg}});

    assign adaptive = (opt_reg == gou_pkg::OPT_ADAGRAD) || (opt_reg == gou_pkg::OPT_RMSPROP)
                   || (opt_reg == gou_pkg::OPT_ADAM);

    // state memory: one row of {m2, m1, v, w} per entry
    assign addr = ADDR_W'(red_reg);

    gou_ram #(
        .WIDTH (gou_pkg::ROW_W),
        .DEPTH (ENTRY_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    assign w_old  = ram_rdata[VW-1:0];
    assign v_old  = ram_rdata[2*VW-1:VW];
    assign m1_old = ram_rdata[3*VW-1:2*VW];
    assign m2_old = ram_rdata[4*VW-1:3*VW];

    assign ram_re = (state_reg == S_READ);
    assign ram_we = (state_reg == S_WB);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_acc) state_next = NEED_RED ? S_RED : S_READ;
            S_RED:  if (k_reg == 4'd0) state_next = S_READ;
            S_READ: state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_ACC;
            S_ACC:  state_next = S_MUL3;
            S_MUL3: state_next = (adaptive && !load_reg) ? S_SQRT : S_WB;
            S_SQRT: if (sqrt_done) state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_WB;
            S_WB:   state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture item and reduce the index modulo ENTRY_COUNT
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            load_reg <= !s_tuser;
            idx_reg  <= s_tdata[gou_pkg::INDEX_W-1:0];
            red_reg  <= s_tdata[gou_pkg::INDEX_W-1:0];
            val_reg  <= s_tdata[gou_pkg::INDEX_W +: VW];
            opt_reg  <= opt_cfg_reg;
            k_reg    <= 4'(gou_pkg::INDEX_W - 1);
        end
        else if (state_reg == S_RED)
        begin
            if ((32'(red_reg)) >= (32'(ENTRY_COUNT) << k_reg))
            begin
                red_reg <= gou_pkg::INDEX_W'((32'(red_reg)) - (32'(ENTRY_COUNT) << k_reg));
            end
            k_reg <= k_reg - 4'd1;
        end
    end

    // products of the gradient, the rates and the stored values
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1)
        begin
            p_mu_v  <= mu_s * v_old;
            p_lr_g  <= lr_s * val_reg;
            p_gg    <= val_reg * val_reg;
            p_omu_g <= omu_s * val_reg;
            p_mu_m1 <= mu_s * m1_old;
            p_b2_m2 <= gou_pkg::BETA2_Q16 * m2_old;
        end
        if (state_reg == S_MUL2)
        begin
            sqr_reg  <= sqr_w[47:0];
            p_omu_sq <= omu_s * $signed(sqr_w[47:0]);
            p_66_sq  <= gou_pkg::ONE_M_BETA2 * $signed(sqr_w[47:0]);
        end
    end

    assign sqr_w = gou_pkg::rnd16(gou_pkg::wide_t'(p_gg));

    // new accumulators
    assign v_mom_w = gou_pkg::rnd16(gou_pkg::wide_t'(p_mu_v))
                   - gou_pkg::rnd16(gou_pkg::wide_t'(p_lr_g));
    assign v_ada_w = gou_pkg::wide_t'(v_old) + gou_pkg::wide_t'(sqr_reg);
    assign v_rms_w = gou_pkg::rnd16(gou_pkg::wide_t'(p_mu_v))
                   + gou_pkg::rnd16(gou_pkg::wide_t'(p_omu_sq));
    assign m1_w    = gou_pkg::rnd16(gou_pkg::wide_t'(p_mu_m1))
                   + gou_pkg::rnd16(gou_pkg::wide_t'(p_omu_g));
    assign m2_w    = gou_pkg::rnd16(gou_pkg::wide_t'(p_b2_m2))
                   + gou_pkg::rnd16(gou_pkg::wide_t'(p_66_sq));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC)
        begin
            v_new_reg    <= v_old;
            m1_new_reg   <= m1_old;
            m2_new_reg   <= m2_old;
            acc_clip_reg <= 1'b0;
            if (!load_reg)
            begin
                unique case (opt_reg)
                    gou_pkg::OPT_MOMENTUM, gou_pkg::OPT_NESTEROV:
                    begin
                        v_new_reg    <= gou_pkg::sat_val(v_mom_w);
                        acc_clip_reg <= gou_pkg::clip_val(v_mom_w);
                    end
                    gou_pkg::OPT_ADAGRAD:
                    begin
                        v_new_reg    <= gou_pkg::sat_val(v_ada_w);
                        acc_clip_reg <= gou_pkg::clip_val(v_ada_w);
                    end
                    gou_pkg::OPT_RMSPROP:
                    begin
                        v_new_reg    <= gou_pkg::sat_val(v_rms_w);
                        acc_clip_reg <= gou_pkg::clip_val(v_rms_w);
                    end
                    gou_pkg::OPT_ADAM:
                    begin
                        m1_new_reg   <= gou_pkg::sat_val(m1_w);
                        m2_new_reg   <= gou_pkg::sat_val(m2_w);
                        acc_clip_reg <= gou_pkg::clip_val(m1_w) || gou_pkg::clip_val(m2_w);
                    end
                    default: ;
                endcase
            end
        end
        if (state_reg == S_MUL3)
        begin
            p_mu_vn  <= mu_s * v_new_reg;
            p_lr_num <= lr_s * ((opt_reg == gou_pkg::OPT_ADAM) ? m1_new_reg : val_reg);
        end
    end

    // root(acc) + 1 divides lr * num
    assign root_src   = (opt_reg == gou_pkg::OPT_ADAM) ? m2_new_reg : v_new_reg;
    assign sqrt_start = (state_reg == S_MUL3) && adaptive && !load_reg;
    assign div_start  = (state_reg == S_SQRT) && sqrt_done;

    gou_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (root_src[VW-1] ? '0 : {root_src, 16'h0000}),
        .done     (sqrt_done),
        .root     (root)
    );

    gou_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (p_lr_num),
        .divisor  ({1'b0, root} + gou_pkg::DIVISOR_W'(1)),
        .done     (div_done),
        .quotient (quotient)
    );

    // weight update
    always_comb
    begin
        unique case (opt_reg)
            gou_pkg::OPT_SGD:
                w_sum = gou_pkg::wide_t'(w_old) - gou_pkg::rnd16(gou_pkg::wide_t'(p_lr_g));
            gou_pkg::OPT_MOMENTUM:
                w_sum = gou_pkg::wide_t'(w_old) + gou_pkg::wide_t'(v_new_reg);
            gou_pkg::OPT_NESTEROV:
                w_sum = gou_pkg::wide_t'(w_old) + gou_pkg::rnd16(gou_pkg::wide_t'(p_mu_vn))
                      - gou_pkg::rnd16(gou_pkg::wide_t'(p_lr_g));
            gou_pkg::OPT_ADAGRAD, gou_pkg::OPT_RMSPROP, gou_pkg::OPT_ADAM:
                w_sum = gou_pkg::wide_t'(w_old) - gou_pkg::wide_t'(quotient);
            default:
                w_sum = gou_pkg::wide_t'(w_old);
        endcase
    end

    assign w_clip = gou_pkg::clip_val(w_sum);

    always_comb
    begin
        if (load_reg)
        begin
            ram_wdata = {{(3 * VW){1'b0}}, val_reg};
        end
        else
        begin
            ram_wdata = {m2_new_reg, m1_new_reg, v_new_reg, gou_pkg::sat_val(w_sum)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WB)
        begin
            w_res_reg <= ram_wdata[VW-1:0];
            if (load_reg)
            begin
                status_reg <= gou_pkg::STATUS_OK;
            end
            else if (opt_reg == gou_pkg::OPT_NONE || opt_reg == gou_pkg::OPT_RESERVED)
            begin
                status_reg <= gou_pkg::STATUS_DISABLED;
            end
            else if (acc_clip_reg || w_clip)
            begin
                status_reg <= gou_pkg::STATUS_SAT;
            end
            else
            begin
                status_reg <= gou_pkg::STATUS_OK;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if ((state_reg == S_OUT) && out_free)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            m_tdata <= {4'b0000, status_reg, w_res_reg, idx_reg};
        end
    end

endmodule

>>> rtl/gou_checker.sv
// Port-level checks for gradient_optimizer_update, bound to the top level.
// Depends on gou_pkg for the status codes.
module gou_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [47:0]                   m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a new result frees the input side at once
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown without returning to idle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[43:42] != gou_pkg::STATUS_UNUSED)
        else $error("reserved status code");

endmodule

bind gradient_optimizer_update gou_checker u_gou_checker (.*);
